@@ hw/rtl/utba_pkg.sv @@
// Shared types, constants and helper functions for the base conversion unit.
package utba_pkg;

    // Default sizes.
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF  = 32;

    // Field widths.
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;
    localparam int STEP_W  = 3;

    // Radix limits and reset value.
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // Character mapping constants.
    localparam logic [CHAR_W-1:0]  LETTER_OFFSET = 7'd55;
    localparam logic [CHAR_W-1:0]  DIGIT_ZERO    = 7'd48;
    localparam logic [RADIX_W-1:0] LAST_DECIMAL  = 6'd9;

    // Microprogram step addresses.
    localparam logic [STEP_W-1:0] STEP_IDLE     = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DIV_INIT = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DIV_BIT  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_STORE    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_READ     = 3'd4;
    localparam logic [STEP_W-1:0] STEP_EMIT     = 3'd5;
    localparam logic [STEP_W-1:0] STEP_DONE     = 3'd6;

    // Datapath operation selected by a control word.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_INIT,
        OP_DIV_BIT,
        OP_STORE,
        OP_READ,
        OP_EMIT
    } op_t;

    // Condition the step waits on before it executes.
    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_INPUT,
        WAIT_OUT
    } wait_t;

    // Jump condition, evaluated once the step executes.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_BITS_LEFT,
        COND_MORE_DIGITS,
        COND_IDX_NZ
    } cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        op_t              op;
        wait_t            wait_sel;
        cond_t            cond;
        logic [STEP_W-1:0] target;
    } ctl_word_t;

    // Command from the sequencer to the datapath.
    typedef struct packed {
        op_t  op;
        logic exec;
    } dp_cmd_t;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic bits_left;
        logic more_digits;
        logic idx_nz;
    } dp_status_t;

    // Clamp a written radix into the supported range.
    function automatic logic [RADIX_W-1:0] saturate_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    // Map a digit value to its ASCII character.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d > LAST_DECIMAL) begin
            res = {1'b0, d} + LETTER_OFFSET;
        end else begin
            res = {1'b0, d} + DIGIT_ZERO;
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/unsigned_to_base_ascii_unit.sv @@
// Top level of the unsigned binary to ASCII digit conversion unit.
// Converts each accepted value into its digits in the configured radix (2 to 36, values
// outside that range are clamped) and sends them out one character per request, most
// significant first, with m_last on the final character; zero gives a single '0'. One
// value is handled at a time: the unit is not ready for the next value until every
// digit has been computed by the bit-serial divider and sent to the output register. The
// divider produces one quotient bit per cycle and works through all VALUE_WIDTH bits of
// the value for each digit. The output register lets the next value be accepted while
// the final character still waits to be taken. The radix may only be written while no
// conversion is in progress.
module unsigned_to_base_ascii_unit #(
    parameter int VALUE_WIDTH = utba_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = utba_pkg::MAX_DIGITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [utba_pkg::RADIX_W-1:0] cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [VALUE_WIDTH-1:0]       s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [utba_pkg::CHAR_W-1:0]  m_character,
    output logic                         m_last
);
    import utba_pkg::*;

    logic [RADIX_W-1:0] base_reg;
    dp_cmd_t            cmd;
    dp_status_t         status;
    logic               out_free;

    // Radix register, clamped on write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= RADIX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            base_reg <= saturate_radix(cfg_data);
        end
    end

    utba_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .in_ready (s_ready)
    );

    utba_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_value      (s_value),
        .base          (base_reg),
        .out_ready     (m_ready),
        .status        (status),
        .out_free      (out_free),
        .out_valid     (m_valid),
        .out_character (m_character),
        .out_last      (m_last)
    );

    // A new value is never taken in the cycle right after one was accepted.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice in a row");

    // Every character sent is a digit or an upper-case letter.
    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_character >= 7'd48 && m_character <= 7'd57) ||
                     (m_character >= 7'd65 && m_character <= 7'd90)))
        else $error("character out of range");

    // The working radix always stays within the supported range.
    a_base_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (base_reg >= RADIX_MIN) && (base_reg <= RADIX_MAX))
        else $error("radix out of range");

endmodule

@@ hw/rtl/utba_ctl_rom.sv @@
// Read-only microprogram store of the base conversion unit.
module utba_ctl_rom (
    input  logic [utba_pkg::STEP_W-1:0] step,
    output utba_pkg::ctl_word_t         ctl
);
    import utba_pkg::*;

    // One control word per step; the division step loops on itself.
    always_comb begin
        unique case (step)
            STEP_IDLE:     ctl = '{op: OP_LOAD,     wait_sel: WAIT_INPUT, cond: COND_NEVER,
                                   target: STEP_IDLE};
            STEP_DIV_INIT: ctl = '{op: OP_DIV_INIT, wait_sel: WAIT_NONE,  cond: COND_NEVER,
                                   target: STEP_IDLE};
            STEP_DIV_BIT:  ctl = '{op: OP_DIV_BIT,  wait_sel: WAIT_NONE,  cond: COND_BITS_LEFT,
                                   target: STEP_DIV_BIT};
            STEP_STORE:    ctl = '{op: OP_STORE,    wait_sel: WAIT_NONE,  cond: COND_MORE_DIGITS,
                                   target: STEP_DIV_INIT};
            STEP_READ:     ctl = '{op: OP_READ,     wait_sel: WAIT_NONE,  cond: COND_NEVER,
                                   target: STEP_IDLE};
            STEP_EMIT:     ctl = '{op: OP_EMIT,     wait_sel: WAIT_OUT,   cond: COND_IDX_NZ,
                                   target: STEP_READ};
            STEP_DONE:     ctl = '{op: OP_NOP,      wait_sel: WAIT_NONE,  cond: COND_ALWAYS,
                                   target: STEP_IDLE};
            default:       ctl = '{op: OP_NOP,      wait_sel: WAIT_NONE,  cond: COND_ALWAYS,
                                   target: STEP_IDLE};
        endcase
    end

endmodule

@@ hw/rtl/utba_sequencer.sv @@
// Step counter and jump logic that walks the microprogram.
module utba_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 out_free,
    input  utba_pkg::dp_status_t status,
    output utba_pkg::dp_cmd_t    cmd,
    output logic                 in_ready
);
    import utba_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ctl_word_t         ctl;
    logic              wait_ok;
    logic              cond_true;

    utba_ctl_rom u_rom (
        .step (step_reg),
        .ctl  (ctl)
    );

    // A step executes only once its wait condition is met.
    always_comb begin
        unique case (ctl.wait_sel)
            WAIT_NONE:  wait_ok = 1'b1;
            WAIT_INPUT: wait_ok = in_valid;
            WAIT_OUT:   wait_ok = out_free;
            default:    wait_ok = 1'b0;
        endcase
    end

    // Jump condition select.
    always_comb begin
        unique case (ctl.cond)
            COND_NEVER:       cond_true = 1'b0;
            COND_ALWAYS:      cond_true = 1'b1;
            COND_BITS_LEFT:   cond_true = status.bits_left;
            COND_MORE_DIGITS: cond_true = status.more_digits;
            COND_IDX_NZ:      cond_true = status.idx_nz;
            default:          cond_true = 1'b0;
        endcase
    end

    // Next step: hold while waiting, else jump or fall through.
    always_comb begin
        priority if (!wait_ok) begin
            step_next = step_reg;
        end else if (cond_true) begin
            step_next = ctl.target;
        end else begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    assign cmd.op   = ctl.op;
    assign cmd.exec = wait_ok;
    assign in_ready = (ctl.wait_sel == WAIT_INPUT);

endmodule

@@ hw/rtl/utba_datapath.sv @@
// Bit-serial divider, digit memory and output register of the base conversion unit.
module utba_datapath #(
    parameter int VALUE_WIDTH = utba_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = utba_pkg::MAX_DIGITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  utba_pkg::dp_cmd_t            cmd,
    input  logic [VALUE_WIDTH-1:0]       in_value,
    input  logic [utba_pkg::RADIX_W-1:0] base,
    input  logic                         out_ready,
    output utba_pkg::dp_status_t         status,
    output logic                         out_free,
    output logic                         out_valid,
    output logic [utba_pkg::CHAR_W-1:0]  out_character,
    output logic                         out_last
);
    import utba_pkg::*;

    localparam int BIT_W = $clog2(VALUE_WIDTH);
    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic [VALUE_WIDTH-1:0] quot_reg;
    logic [RADIX_W-1:0]     rem_reg;
    logic [BIT_W-1:0]       bit_cnt_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [RADIX_W-1:0]     rdata_reg;
    logic                   out_valid_reg;
    logic [CHAR_W-1:0]      out_char_reg;
    logic                   out_last_reg;
    logic [RADIX_W-1:0]     digit_mem [MAX_DIGITS];

    logic [RADIX_W:0]       trial;
    logic                   q_bit;
    logic [RADIX_W-1:0]     rem_next;
    logic                   do_op;

    assign do_op = cmd.exec;

    // One restoring division step: bring down the next dividend bit.
    always_comb begin
        trial = {rem_reg, quot_reg[VALUE_WIDTH-1]};
        q_bit = (trial >= {1'b0, base});
        if (q_bit) begin
            rem_next = RADIX_W'(trial - {1'b0, base});
        end else begin
            rem_next = trial[RADIX_W-1:0];
        end
    end

    // Division and digit bookkeeping registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quot_reg    <= '0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
        end else if (do_op) begin
            unique case (cmd.op)
                OP_LOAD: begin
                    quot_reg <= in_value;
                    cnt_reg  <= '0;
                end
                OP_DIV_INIT: begin
                    rem_reg     <= '0;
                    bit_cnt_reg <= '0;
                end
                OP_DIV_BIT: begin
                    quot_reg    <= {quot_reg[VALUE_WIDTH-2:0], q_bit};
                    rem_reg     <= rem_next;
                    bit_cnt_reg <= bit_cnt_reg + BIT_W'(1);
                end
                OP_STORE: begin
                    idx_reg <= cnt_reg[IDX_W-1:0];
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                OP_EMIT: begin
                    idx_reg <= idx_reg - IDX_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Digit memory: written while dividing, read back most significant first.
    always_ff @(posedge aclk) begin
        if (do_op && (cmd.op == OP_STORE)) begin
            digit_mem[cnt_reg[IDX_W-1:0]] <= rem_reg;
        end
        if (do_op && (cmd.op == OP_READ)) begin
            rdata_reg <= digit_mem[idx_reg];
        end
    end

    // Output register decouples the result side from the sequencer.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (do_op && (cmd.op == OP_EMIT)) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_op && (cmd.op == OP_EMIT)) begin
            out_char_reg <= digit_to_ascii(rdata_reg);
            out_last_reg <= (idx_reg == '0);
        end
    end

    // Status for the jump conditions.
    assign status.bits_left   = (bit_cnt_reg != BIT_W'(VALUE_WIDTH - 1));
    assign status.more_digits = (quot_reg != '0) && (cnt_reg < CNT_W'(MAX_DIGITS - 1));
    assign status.idx_nz      = (idx_reg != '0);

    assign out_valid     = out_valid_reg;
    assign out_character = out_char_reg;
    assign out_last      = out_last_reg;

endmodule
